>>> hw/rtl/annexb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_pkg
// Types and constants shared by the Annex B start code parser modules.
// ----------------------------------------------------------------------------
package annexb_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int PAYLOAD_W       = 24;
  localparam int COUNT_W         = 32;
  localparam int OUT_TDATA_W     = 104;
  localparam int OUT_FIELDS_W    = 99;

  localparam logic [7:0] START_BYTE   = 8'h01;
  localparam logic [2:0] LEAD_MAX     = 3'd4;
  localparam logic [2:0] LEAD_THREE   = 3'd3;
  localparam logic [2:0] PREFIX_THREE = 3'd3;
  localparam logic [2:0] PREFIX_FOUR  = 3'd4;

  typedef enum logic [1:0] {
    PHASE_LEAD,
    PHASE_UNIT,
    PHASE_ERROR
  } phase_t;

  typedef struct packed {
    logic       end_of_stream;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic                 format_error;
    logic                 f_bit;
    logic [1:0]           ref_idc;
    logic [4:0]           unit_type;
    logic [PAYLOAD_W-1:0] payload_length;
    logic [2:0]           prefix_length;
    logic [COUNT_W-1:0]   unit_number;
    logic [COUNT_W-1:0]   start_offset;
  } result_t;

  // output of the parse stage towards the result register
  typedef struct packed {
    logic    emit;
    result_t res;
  } parse_out_t;

endpackage

>>> hw/rtl/annexb_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_in_stage
// Input register: holds one byte item until the parse stage takes it.
// ----------------------------------------------------------------------------
module annexb_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  output logic                s_ready,
  input  annexb_pkg::in_item_t s_item,
  input  logic                take,
  output logic                q_valid,
  output annexb_pkg::in_item_t q_item
);
  import annexb_pkg::*;

  assign s_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_valid && s_ready) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      q_item <= s_item;
    end
  end

  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> q_valid) else $error("item taken from empty input register");

  a_hold_untaken: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !take) |=> q_valid) else $error("input item lost");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !q_valid |-> s_ready) else $error("empty input register not ready");

endmodule

>>> hw/rtl/annexb_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_parser
// Start code search, unit tracking and result formation, one byte per cycle while go is high.
// ----------------------------------------------------------------------------
module annexb_parser #(
  parameter int LENGTH_BITS = annexb_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  annexb_pkg::in_item_t   item,
  output annexb_pkg::parse_out_t pout
);
  import annexb_pkg::*;

  localparam int CNT_W = LENGTH_BITS + 1;
  // saturation point of the byte count: length max plus four
  localparam logic [CNT_W-1:0] CNT_CAP = {1'b1, {(LENGTH_BITS - 2){1'b0}}, 2'b11};
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_FOUR  = CNT_W'(4);

  logic [23:0]        recent, recent_next;
  phase_t             phase, phase_next;
  logic [2:0]         lead_count, lead_next;
  logic [CNT_W-1:0]   byte_count, byte_count_next;
  logic               prefix_four, prefix_four_next;
  logic [7:0]         header, header_next;
  logic [COUNT_W-1:0] units, units_next;
  logic [COUNT_W-1:0] stream_pos, stream_pos_next;
  logic [COUNT_W-1:0] unit_start, unit_start_next;

  logic [7:0]       b;
  logic             eos;
  logic             match3, match4;
  logic [2:0]       lead_inc;
  logic             open3, open4, lead_err;
  logic [CNT_W-1:0] cnt_inc;
  logic             cut4, cut3;
  logic [7:0]       hdr_now;
  logic             emit_raw;
  result_t          res;

  function automatic result_t unit_result(input logic [7:0] hdr,
                                          input logic [CNT_W-1:0] len,
                                          input logic four,
                                          input logic [COUNT_W-1:0] num,
                                          input logic [COUNT_W-1:0] start);
    result_t r;
    logic [LENGTH_BITS-1:0] len_sat;
    len_sat = len[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : len[LENGTH_BITS-1:0];
    r = '0;
    r.f_bit          = hdr[7];
    r.ref_idc        = hdr[6:5];
    r.unit_type      = hdr[4:0];
    r.payload_length = PAYLOAD_W'(len_sat);
    r.prefix_length  = four ? PREFIX_FOUR : PREFIX_THREE;
    r.unit_number    = num;
    r.start_offset   = start;
    return r;
  endfunction

  assign b   = item.data_byte;
  assign eos = item.end_of_stream;

  assign match3 = (recent[15:0] == 16'h0000) && (b == START_BYTE);
  assign match4 = (recent == 24'h000000) && (b == START_BYTE);

  assign lead_inc = (lead_count < LEAD_MAX) ? lead_count + 3'd1 : lead_count;
  assign open3    = (lead_inc == LEAD_THREE) && match3;
  assign open4    = !open3 && (lead_inc >= LEAD_MAX) && match4;
  assign lead_err = !open3 && (lead_inc >= LEAD_MAX) && !match4;

  assign cnt_inc = (byte_count < CNT_CAP) ? byte_count + CNT_ONE : byte_count;
  assign hdr_now = (cnt_inc == CNT_ONE) ? b : header;
  assign cut4    = (cnt_inc >= CNT_FOUR) && match4;
  assign cut3    = !cut4 && (cnt_inc >= CNT_THREE) && match3;

  always_comb begin
    recent_next      = {recent[15:0], b};
    phase_next       = phase;
    lead_next        = lead_count;
    byte_count_next  = byte_count;
    prefix_four_next = prefix_four;
    header_next      = header;
    units_next       = units;
    stream_pos_next  = stream_pos + 32'd1;
    unit_start_next  = unit_start;
    emit_raw         = 1'b0;
    res              = '0;

    unique case (phase)
      PHASE_LEAD: begin
        lead_next = lead_inc;
        if (open3 || open4) begin
          phase_next       = PHASE_UNIT;
          prefix_four_next = open4;
          byte_count_next  = '0;
          header_next      = 8'h00;
          unit_start_next  = open4 ? stream_pos - 32'd3 : stream_pos - 32'd2;
        end
        if (lead_err) begin
          emit_raw         = 1'b1;
          res.format_error = 1'b1;
          phase_next       = PHASE_ERROR;
        end else if (eos) begin
          emit_raw = 1'b1;
          if (open3 || open4) begin
            // stream was exactly one start code: empty unit
            res = unit_result(8'h00, '0, open4, units,
                              open4 ? stream_pos - 32'd3 : stream_pos - 32'd2);
            units_next = units + 32'd1;
          end else begin
            res.format_error = 1'b1;
          end
        end
      end
      PHASE_UNIT: begin
        byte_count_next = cnt_inc;
        header_next     = hdr_now;
        if (cut4 || cut3) begin
          emit_raw = 1'b1;
          res = unit_result(hdr_now, cnt_inc - (cut4 ? CNT_FOUR : CNT_THREE),
                            prefix_four, units, unit_start);
          units_next       = units + 32'd1;
          prefix_four_next = cut4;
          byte_count_next  = '0;
          header_next      = 8'h00;
          unit_start_next  = cut4 ? stream_pos - 32'd3 : stream_pos - 32'd2;
        end else if (eos) begin
          emit_raw   = 1'b1;
          res        = unit_result(hdr_now, cnt_inc, prefix_four, units, unit_start);
          units_next = units + 32'd1;
        end
      end
      default: begin
        // error phase: bytes ignored until end of stream
      end
    endcase

    // end of stream puts everything back to its reset state
    if (eos) begin
      recent_next      = '0;
      phase_next       = PHASE_LEAD;
      lead_next        = '0;
      byte_count_next  = '0;
      prefix_four_next = 1'b0;
      header_next      = 8'h00;
      units_next       = '0;
      stream_pos_next  = '0;
      unit_start_next  = '0;
    end
  end

  assign pout.emit = go && emit_raw;
  assign pout.res  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      recent      <= '0;
      phase       <= PHASE_LEAD;
      lead_count  <= '0;
      byte_count  <= '0;
      prefix_four <= 1'b0;
      header      <= 8'h00;
      units       <= '0;
      stream_pos  <= '0;
      unit_start  <= '0;
    end else if (go) begin
      recent      <= recent_next;
      phase       <= phase_next;
      lead_count  <= lead_next;
      byte_count  <= byte_count_next;
      prefix_four <= prefix_four_next;
      header      <= header_next;
      units       <= units_next;
      stream_pos  <= stream_pos_next;
      unit_start  <= unit_start_next;
    end
  end

  a_eos_restarts: assert property (@(posedge clk) disable iff (rst)
    (go && eos) |=> (phase == PHASE_LEAD && stream_pos == '0 && units == '0))
    else $error("state not cleared after end of stream");

  a_error_from_lead: assert property (@(posedge clk) disable iff (rst)
    (pout.emit && pout.res.format_error) |-> (phase == PHASE_LEAD))
    else $error("format error outside the leading start code");

  a_lead_bound: assert property (@(posedge clk) disable iff (rst)
    lead_count <= LEAD_MAX) else $error("lead count out of range");

  a_error_silent: assert property (@(posedge clk) disable iff (rst)
    (phase == PHASE_ERROR) |-> !pout.emit)
    else $error("result emitted while ignoring bytes");

endmodule

>>> hw/rtl/annexb_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_out_stage
// Result register: holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
module annexb_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  annexb_pkg::parse_out_t pout,
  output logic                   space,
  output logic                   m_valid,
  input  logic                   m_ready,
  output annexb_pkg::result_t    m_res
);
  import annexb_pkg::*;

  assign space = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (pout.emit) begin
      m_valid <= 1'b1;
    end else if (m_ready) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pout.emit) begin
      m_res <= pout.res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    pout.emit |-> space) else $error("pending result overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    pout.emit |=> m_valid) else $error("loaded result not presented");

  a_unit_prefix: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_res.format_error) |->
      (m_res.prefix_length == PREFIX_THREE || m_res.prefix_length == PREFIX_FOUR))
    else $error("bad prefix length on unit result");

endmodule

>>> hw/rtl/annexb_nal_unit_splitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_top
// H.264 Annex B start code parser: splits a byte stream into NAL units and
// reports header fields, length, prefix size, unit number and offset.
//
//   channel  dir  handshake          tdata / tuser
//   s_*      in   s_tvalid/s_tready  byte of stream, tlast = end of stream
//   m_*      out  m_tvalid/m_tready  unit fields, tuser = format error
//
// datapath: an accepted byte waits in the input register, then is parsed into
// the result register; one byte per cycle sustained while no held result waits,
// limited by the combinational start code compare and counter update.
// reset: rst clears the parse state; the next byte starts a new stream.
// stalls: a held result that is not taken stops parsing, whether or not the
// next byte makes a result; the input register keeps one byte while it waits.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter_top #(
  parameter int LENGTH_BITS = annexb_pkg::LENGTH_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // data_byte
  input  logic         s_tlast,   // end_of_stream
  output logic         m_tvalid,
  input  logic         m_tready,
  // f_bit, ref_idc, unit_type, payload_length, prefix_length,
  // unit_number, start_offset, zero fill
  output logic [103:0] m_tdata,
  output logic         m_tuser    // format_error
);
  import annexb_pkg::*;

  in_item_t   s_item;
  in_item_t   q_item;
  logic       q_valid;
  logic       space;
  logic       go;
  parse_out_t pout;
  result_t    m_res;

  assign s_item.data_byte     = s_tdata;
  assign s_item.end_of_stream = s_tlast;
  assign go = q_valid && space;

  annexb_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_tvalid),
    .s_ready (s_tready),
    .s_item  (s_item),
    .take    (go),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  annexb_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (q_item),
    .pout (pout)
  );

  annexb_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .pout    (pout),
    .space   (space),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_res   (m_res)
  );

  assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                    m_res.start_offset, m_res.unit_number, m_res.prefix_length,
                    m_res.payload_length, m_res.unit_type, m_res.ref_idc,
                    m_res.f_bit};
  assign m_tuser = m_res.format_error;

  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("format error result carries unit fields");

  a_go_on_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> q_valid) else $error("accepted item not held");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("waiting result changed");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives Annex B byte streams into the NAL unit splitter. A short table of
// hand-picked streams comes first, then random streams, mostly well formed
// with random unit contents and some noise. Every unit report is checked
// field by field against the typed table rows or a byte-level parser model in this file.
// ----------------------------------------------------------------------------
module testbench;
  import annexb_pkg::*;

  localparam int TOTAL_BYTES = 450;
  localparam logic [24:0] CNT_CAP = 25'((1 << PAYLOAD_W) + 3);
  localparam logic [24:0] LEN_MAX = 25'((1 << PAYLOAD_W) - 1);

  // expectations that can be read straight off the spec
  localparam result_t FMT_ERR   = {1'b1, 99'd0};
  localparam result_t LONE_CODE = {1'b0, 1'b0, 2'd0, 5'd0, 24'd0, PREFIX_THREE,
                                   32'd0, 32'd0};
  localparam result_t NO_TYPED  = '0;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    result_t    want;
  } dir_row_t;

  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // no start code at the head: one error, rest ignored
    {8'h47, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h01, 1'b0, 1'b1, FMT_ERR},
    {8'hAA, 1'b1, 1'b0, NO_TYPED},
    // stream that is a single start code
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h01, 1'b1, 1'b1, LONE_CODE},
    // stream ends inside the leading start code
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b1, 1'b1, FMT_ERR},
    // 4-byte lead, all-ones header, empty unit, end byte closes a start code
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h01, 1'b0, 1'b0, NO_TYPED},
    {8'hFF, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h01, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h01, 1'b0, 1'b0, NO_TYPED},
    {8'h65, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h00, 1'b0, 1'b0, NO_TYPED},
    {8'h01, 1'b1, 1'b0, NO_TYPED}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = 8'h00;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [103:0] m_tdata;
  logic         m_tuser;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  annexb_nal_unit_splitter_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // parser model state
  logic [23:0] recent;
  phase_t      phase;
  logic [2:0]  lead_cnt;
  logic [24:0] unit_cnt;
  logic        pfx_four;
  logic [7:0]  hdr;
  logic [31:0] unit_no;
  logic [31:0] byte_pos;
  logic [31:0] unit_pos;

  result_t pending_units[$];
  int      mismatches = 0;
  int      items_sent = 0;
  bit      steady = 1'b0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;

  function automatic void restart_parser();
    recent   = '0;
    phase    = PHASE_LEAD;
    lead_cnt = '0;
    unit_cnt = '0;
    pfx_four = 1'b0;
    hdr      = '0;
    unit_no  = '0;
    byte_pos = '0;
    unit_pos = '0;
  endfunction

  function automatic void open_unit(input logic four, input logic [31:0] code_pos);
    phase    = PHASE_UNIT;
    pfx_four = four;
    unit_cnt = '0;
    hdr      = '0;
    unit_pos = code_pos;
  endfunction

  function automatic result_t close_unit(input logic [24:0] len);
    result_t r;
    r.format_error   = 1'b0;
    r.f_bit          = hdr[7];
    r.ref_idc        = hdr[6:5];
    r.unit_type      = hdr[4:0];
    r.payload_length = (len > LEN_MAX) ? LEN_MAX[23:0] : len[23:0];
    r.prefix_length  = pfx_four ? PREFIX_FOUR : PREFIX_THREE;
    r.unit_number    = unit_no;
    r.start_offset   = unit_pos;
    unit_no = unit_no + 32'd1;
    return r;
  endfunction

  // one stream byte through the parser model
  task automatic parse_byte(input logic [7:0] b, input logic eos,
                            output bit got, output result_t res);
    logic [31:0] w;
    logic [31:0] p;
    logic        m3;
    logic        m4;
    logic [2:0]  k;
    w  = {recent, b};
    p  = byte_pos;
    m3 = (w[23:0] == 24'h000001);
    m4 = (w == 32'h00000001);
    k  = 3'd0;
    got = 1'b0;
    res = '0;
    recent   = w[23:0];
    byte_pos = p + 32'd1;
    case (phase)
      PHASE_LEAD: begin
        if (lead_cnt < LEAD_MAX) lead_cnt = lead_cnt + 3'd1;
        if (lead_cnt == LEAD_THREE && m3) begin
          open_unit(1'b0, p - 32'd2);
        end else if (lead_cnt >= LEAD_MAX) begin
          if (m4) begin
            open_unit(1'b1, p - 32'd3);
          end else begin
            res = FMT_ERR;
            got = 1'b1;
            phase = PHASE_ERROR;
          end
        end
        if (eos && !got) begin
          res = (phase == PHASE_UNIT) ? close_unit(25'd0) : FMT_ERR;
          got = 1'b1;
        end
      end
      PHASE_UNIT: begin
        if (unit_cnt < CNT_CAP) unit_cnt = unit_cnt + 25'd1;
        if (unit_cnt == 25'd1) hdr = b;
        if (unit_cnt >= 25'd4 && m4) k = PREFIX_FOUR;
        else if (unit_cnt >= 25'd3 && m3) k = PREFIX_THREE;
        if (k != 3'd0) begin
          res = close_unit(unit_cnt - 25'(k));
          got = 1'b1;
          open_unit(k == PREFIX_FOUR, p - 32'(k - 3'd1));
        end else if (eos) begin
          res = close_unit(unit_cnt);
          got = 1'b1;
        end
      end
      default: ;
    endcase
    if (eos) restart_parser();
  endtask

  task automatic flag_field(input string name, input longint unsigned got,
                            input longint unsigned want);
    if (got != want) begin
      $display("mismatch %s: got %0h expected %0h at %0t", name, got, want, $realtime);
      mismatches++;
    end
  endtask

  task automatic check_unit();
    result_t want;
    if (pending_units.size() == 0) begin
      flag_field("unexpected unit report", 1, 0);
    end else begin
      want = pending_units.pop_front();
      flag_field("format_error", m_tuser, want.format_error);
      flag_field("f_bit", m_tdata[0], want.f_bit);
      flag_field("ref_idc", m_tdata[2:1], want.ref_idc);
      flag_field("unit_type", m_tdata[7:3], want.unit_type);
      flag_field("payload_length", m_tdata[31:8], want.payload_length);
      flag_field("prefix_length", m_tdata[34:32], want.prefix_length);
      flag_field("unit_number", m_tdata[66:35], want.unit_number);
      flag_field("start_offset", m_tdata[98:67], want.start_offset);
      flag_field("zero fill", m_tdata[103:99], 0);
    end
  endtask

  // result side: check, then pick tready for the next cycle
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_unit();
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && items_sent >= 150) begin
      // long hold-off so the block backs up into its input
      hold_done = 1'b1;
      hold_left = 300;
      m_tready <= 1'b0;
    end else begin
      m_tready <= steady || ($urandom_range(0, 99) >= 24);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    items_sent++;
    steady = (items_sent >= 220 && items_sent < 320);
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic last);
    bit      got;
    result_t res;
    send_byte(b, last);
    parse_byte(b, last, got, res);
    if (got) pending_units.push_back(res);
  endtask

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 7);
    // lean on zeros and ones so stray start codes turn up inside units
    if (r == 0) return 8'h00;
    if (r == 1) return 8'h01;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_code(ref logic [7:0] q[$]);
    if ($urandom_range(0, 1)) q.push_back(8'h00);
    q.push_back(8'h00);
    q.push_back(8'h00);
    q.push_back(START_BYTE);
  endtask

  task automatic build_stream(ref logic [7:0] q[$]);
    int units;
    int nbytes;
    q.delete();
    if ($urandom_range(0, 4) == 0) begin
      // noise or a broken lead
      nbytes = $urandom_range(1, 10);
      for (int i = 0; i < nbytes; i++) q.push_back(payload_byte());
    end else begin
      push_code(q);
      units = $urandom_range(0, 5);
      for (int u = 0; u < units; u++) begin
        if (u != 0) push_code(q);
        nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                             : $urandom_range(0, 12);
        for (int i = 0; i < nbytes; i++) q.push_back(payload_byte());
      end
      if ($urandom_range(0, 5) == 0) push_code(q);
    end
  endtask

  initial begin
    logic [7:0] stream[$];
    bit         got;
    result_t    res;
    restart_parser();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_byte(DIR_TABLE[i].b, DIR_TABLE[i].last);
      parse_byte(DIR_TABLE[i].b, DIR_TABLE[i].last, got, res);
      if (DIR_TABLE[i].typed) pending_units.push_back(DIR_TABLE[i].want);
      else if (got) pending_units.push_back(res);
    end

    while (items_sent < TOTAL_BYTES) begin
      build_stream(stream);
      foreach (stream[i]) feed_byte(stream[i], i == stream.size() - 1);
    end
    s_tvalid <= 1'b0;

    while (pending_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/annexb_pkg.sv
hw/rtl/annexb_in_stage.sv
hw/rtl/annexb_parser.sv
hw/rtl/annexb_out_stage.sv
hw/rtl/annexb_nal_unit_splitter_top.sv
tb/testbench.sv
